@@ rtl/core/rau_pkg.sv @@
// Package for the rational arithmetic unit: widths, operation codes,
// status codes and the command and status structs between controller and datapath.
// Depends on nothing.
package rau_pkg;

  // Operand width; the ports carry fixed 32-bit fields, but for the 31-bit result denominator.
  localparam int WIDTH = 32;
  localparam int FW    = 32;
  localparam int DW    = 31;
  localparam int PW    = 2 * WIDTH;
  localparam int CW    = $clog2(PW);
  localparam int KW    = $clog2(PW);

  // Status codes of a result.
  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_ERR = 2'd1;
  localparam logic [1:0] STATUS_OVF = 2'd2;

  // Operation codes of an input beat.
  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_INIT,
    OP_MUL_STEP,
    OP_COMBINE,
    OP_GCD_INIT,
    OP_GCD_STEP,
    OP_GCD_END,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_WRITE
  } op_t;

  // Kind of result to write.
  typedef enum logic [1:0] {
    KIND_OK,
    KIND_ERR,
    KIND_ZERO
  } kind_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] sel;
    logic       last;
    kind_t      kind;
  } dp_cmd_t;

  typedef struct packed {
    logic err;
    logic zero;
    logic gcd_done;
  } dp_stat_t;

endpackage

@@ rtl/core/rau_if.sv @@
// Valid/ready channel interfaces for the rational arithmetic unit.
// Depends on nothing; payload widths are the fixed field widths.
interface rau_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] a_num;
  logic [31:0] a_den;
  logic [31:0] b_num;
  logic [31:0] b_den;

  modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] res_num;
  logic [30:0] res_den;
  logic [1:0]  status;

  modport source (output valid, res_num, res_den, status, input ready);
  modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

@@ rtl/core/rau_datapath.sv @@
// Datapath of the rational arithmetic unit: serial multiplier, binary GCD
// and two restoring dividers sharing the divisor. Depends on rau_pkg.
module rau_datapath (
  input  logic                   clk,
  input  rau_pkg::dp_cmd_t       ctl,
  output rau_pkg::dp_stat_t      stat,
  input  logic [1:0]             cmd,
  input  logic [31:0]            a_num,
  input  logic [31:0]            a_den,
  input  logic [31:0]            b_num,
  input  logic [31:0]            b_den,
  output logic [rau_pkg::FW-1:0] res_num,
  output logic [rau_pkg::DW-1:0] res_den,
  output logic [1:0]             status
);

  localparam int W  = rau_pkg::WIDTH;
  localparam int PW = rau_pkg::PW;
  localparam logic [PW-1:0] LIMIT = PW'(1) << (W - 1);

  // Operand magnitudes and signs.
  logic [1:0]    op_cmd;
  logic [W-1:0]  an, ad, bn, bd;
  logic          an_s, ad_s, bn_s, bd_s;
  logic          err;

  // Multiplier state and products.
  logic [PW-1:0] mcand, acc, p0, p1, p2;
  logic [W-1:0]  mplier;

  // Combined numerator and signs.
  logic [PW-1:0] nmag;
  logic          nneg, dneg, zero;

  // GCD and division state.
  logic [PW-1:0] u, v, g;
  logic [rau_pkg::KW-1:0] k;
  logic [PW-1:0] qn, rn, qd, rd;

  logic [W-1:0]  in_an, in_ad, in_bn, in_bd;
  logic [W-1:0]  mx, my;
  logic [PW-1:0] acc_next;
  logic [PW-1:0] m2, sum;
  logic          s1, s2;
  logic [PW-1:0] tn, td;
  logic          neg, over;
  logic [PW-1:0] numv;

  assign in_an = a_num[W-1:0];
  assign in_ad = a_den[W-1:0];
  assign in_bn = b_num[W-1:0];
  assign in_bd = b_den[W-1:0];

  // Multiplier operand selection by product index.
  always_comb begin
    unique case (ctl.sel)
      2'd0: begin
        mx = an;
        my = (op_cmd == rau_pkg::CMD_MUL) ? bn : bd;
      end
      2'd1: begin
        mx = bn;
        my = ad;
      end
      default: begin
        mx = ad;
        my = (op_cmd == rau_pkg::CMD_DIV) ? bn : bd;
      end
    endcase
  end

  assign acc_next = mplier[0] ? acc + mcand : acc;

  // Signed combination of the cross products.
  always_comb begin
    m2 = (op_cmd == rau_pkg::CMD_ADD || op_cmd == rau_pkg::CMD_SUB) ? p1 : '0;
    s1 = an_s ^ ((op_cmd == rau_pkg::CMD_MUL) ? bn_s : bd_s);
    s2 = bn_s ^ ad_s ^ (op_cmd == rau_pkg::CMD_SUB);
    if (s1 == s2) begin
      sum = p0 + m2;
    end else if (p0 >= m2) begin
      sum = p0 - m2;
    end else begin
      sum = m2 - p0;
    end
  end

  // Trial shifts of the two dividers.
  assign tn = {rn[PW-2:0], qn[PW-1]};
  assign td = {rd[PW-2:0], qd[PW-1]};

  // Range check and sign of the reduced result.
  assign neg  = nneg ^ dneg;
  assign over = (neg ? (qn > LIMIT) : (qn > LIMIT - PW'(1))) || (qd > LIMIT - PW'(1));
  assign numv = neg ? (PW'(0) - qn) : qn;

  assign stat.err      = err;
  assign stat.zero     = zero;
  assign stat.gcd_done = (u == '0) || (v == '0);

  // Datapath registers, one operation per cycle.
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      rau_pkg::OP_LOAD: begin
        op_cmd <= cmd;
        an_s   <= in_an[W-1];
        ad_s   <= in_ad[W-1];
        bn_s   <= in_bn[W-1];
        bd_s   <= in_bd[W-1];
        an     <= in_an[W-1] ? W'(0) - in_an : in_an;
        ad     <= in_ad[W-1] ? W'(0) - in_ad : in_ad;
        bn     <= in_bn[W-1] ? W'(0) - in_bn : in_bn;
        bd     <= in_bd[W-1] ? W'(0) - in_bd : in_bd;
        err    <= (in_ad == '0) || (in_bd == '0) ||
                  (cmd == rau_pkg::CMD_DIV && in_bn == '0);
      end
      rau_pkg::OP_MUL_INIT: begin
        mcand  <= PW'(mx);
        mplier <= my;
        acc    <= '0;
      end
      rau_pkg::OP_MUL_STEP: begin
        acc    <= acc_next;
        mcand  <= {mcand[PW-2:0], 1'b0};
        mplier <= {1'b0, mplier[W-1:1]};
        if (ctl.last) begin
          unique case (ctl.sel)
            2'd0:    p0 <= acc_next;
            2'd1:    p1 <= acc_next;
            default: p2 <= acc_next;
          endcase
        end
      end
      rau_pkg::OP_COMBINE: begin
        nmag <= sum;
        nneg <= (s1 == s2 || p0 >= m2) ? s1 : s2;
        dneg <= ad_s ^ ((op_cmd == rau_pkg::CMD_DIV) ? bn_s : bd_s);
        zero <= (sum == '0);
      end
      rau_pkg::OP_GCD_INIT: begin
        u <= nmag;
        v <= p2;
        k <= '0;
      end
      rau_pkg::OP_GCD_STEP: begin
        // Binary GCD: strip common twos, strip lone twos, subtract odds.
        priority if (!u[0] && !v[0]) begin
          u <= u >> 1;
          v <= v >> 1;
          k <= k + 1'b1;
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (u >= v) begin
          u <= u - v;
        end else begin
          v <= v - u;
        end
      end
      rau_pkg::OP_GCD_END: begin
        g <= (u | v) << k;
      end
      rau_pkg::OP_DIV_INIT: begin
        qn <= nmag;
        rn <= '0;
        qd <= p2;
        rd <= '0;
      end
      rau_pkg::OP_DIV_STEP: begin
        if (tn >= g) begin
          rn <= tn - g;
          qn <= {qn[PW-2:0], 1'b1};
        end else begin
          rn <= tn;
          qn <= {qn[PW-2:0], 1'b0};
        end
        if (td >= g) begin
          rd <= td - g;
          qd <= {qd[PW-2:0], 1'b1};
        end else begin
          rd <= td;
          qd <= {qd[PW-2:0], 1'b0};
        end
      end
      rau_pkg::OP_WRITE: begin
        unique case (ctl.kind)
          rau_pkg::KIND_ERR: begin
            res_num <= '0;
            res_den <= '0;
            status  <= rau_pkg::STATUS_ERR;
          end
          rau_pkg::KIND_ZERO: begin
            res_num <= '0;
            res_den <= rau_pkg::DW'(1);
            status  <= rau_pkg::STATUS_OK;
          end
          default: begin
            if (over) begin
              res_num <= '0;
              res_den <= '0;
              status  <= rau_pkg::STATUS_OVF;
            end else begin
              res_num <= rau_pkg::FW'(signed'(numv[W-1:0]));
              res_den <= rau_pkg::DW'(qd[W-2:0]);
              status  <= rau_pkg::STATUS_OK;
            end
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/rau_ctrl.sv @@
// Controller of the rational arithmetic unit: sequences load, three serial
// products, combine, GCD, division and result write. Depends on rau_pkg.
module rau_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output rau_pkg::dp_cmd_t  ctl,
  input  rau_pkg::dp_stat_t stat
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CHK   = 10'b0000000010,
    S_MINIT = 10'b0000000100,
    S_MUL   = 10'b0000001000,
    S_COMB  = 10'b0000010000,
    S_ZCHK  = 10'b0000100000,
    S_GCD   = 10'b0001000000,
    S_DINIT = 10'b0010000000,
    S_DIV   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t                state, state_next;
  logic [rau_pkg::CW-1:0] cnt, cnt_next;
  logic [1:0]            sel, sel_next;
  rau_pkg::kind_t        kind, kind_next;
  logic                  out_valid_next;

  assign in_ready = (state == S_IDLE);

  // Next state and datapath command.
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    sel_next       = sel;
    kind_next      = kind;
    out_valid_next = out_valid && !out_ready;
    ctl.op         = rau_pkg::OP_NONE;
    ctl.sel        = sel;
    ctl.last       = 1'b0;
    ctl.kind       = kind;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.op     = rau_pkg::OP_LOAD;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.err) begin
          kind_next  = rau_pkg::KIND_ERR;
          state_next = S_OUT;
        end else begin
          sel_next   = 2'd0;
          state_next = S_MINIT;
        end
      end
      S_MINIT: begin
        ctl.op     = rau_pkg::OP_MUL_INIT;
        cnt_next   = '0;
        state_next = S_MUL;
      end
      S_MUL: begin
        ctl.op   = rau_pkg::OP_MUL_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == rau_pkg::CW'(rau_pkg::WIDTH - 1)) begin
          ctl.last = 1'b1;
          if (sel == 2'd2) begin
            state_next = S_COMB;
          end else begin
            sel_next   = sel + 2'd1;
            state_next = S_MINIT;
          end
        end
      end
      S_COMB: begin
        ctl.op     = rau_pkg::OP_COMBINE;
        state_next = S_ZCHK;
      end
      S_ZCHK: begin
        if (stat.zero) begin
          kind_next  = rau_pkg::KIND_ZERO;
          state_next = S_OUT;
        end else begin
          ctl.op     = rau_pkg::OP_GCD_INIT;
          state_next = S_GCD;
        end
      end
      S_GCD: begin
        if (stat.gcd_done) begin
          ctl.op     = rau_pkg::OP_GCD_END;
          state_next = S_DINIT;
        end else begin
          ctl.op = rau_pkg::OP_GCD_STEP;
        end
      end
      S_DINIT: begin
        ctl.op     = rau_pkg::OP_DIV_INIT;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        ctl.op   = rau_pkg::OP_DIV_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == rau_pkg::CW'(rau_pkg::PW - 1)) begin
          kind_next  = rau_pkg::KIND_OK;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        // Write the result register once the previous beat has left.
        if (!out_valid || out_ready) begin
          ctl.op         = rau_pkg::OP_WRITE;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
      sel       <= 2'd0;
      kind      <= rau_pkg::KIND_OK;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      cnt       <= cnt_next;
      sel       <= sel_next;
      kind      <= kind_next;
    end
  end

endmodule

@@ rtl/core/rational_arithmetic_unit.sv @@
// Rational arithmetic unit: one item at a time. An accepted beat is checked, then three serial
// 32-bit products are formed and combined, the result is reduced by a binary GCD and divided
// by the GCD in the 64-step dividers before it is written. Error results go straight from the
// check to the write, zero results skip the GCD and the division.
// The next beat is taken in the cycle after the result is written; the write waits while
// the previous result still waits on the output. Synchronous reset clears the controller.
module rational_arithmetic_unit (
  input logic  clk,
  input logic  rst,
  rau_in_if.sink    req,
  rau_out_if.source rsp
);

  rau_pkg::dp_cmd_t  ctl;
  rau_pkg::dp_stat_t stat;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .ctl       (ctl),
    .stat      (stat)
  );

  rau_datapath u_dp (
    .clk     (clk),
    .ctl     (ctl),
    .stat    (stat),
    .cmd     (req.cmd),
    .a_num   (req.a_num),
    .a_den   (req.a_den),
    .b_num   (req.b_num),
    .b_den   (req.b_den),
    .res_num (rsp.res_num),
    .res_den (rsp.res_den),
    .status  (rsp.status)
  );

endmodule
